// ===== rtl/core/nsc_pkg.sv =====
// nsc_pkg: types, codes and constants of the sentence checker
// used by nsc_track, nsc_verdict and nmea_sentence_checker; no dependencies
package nsc_pkg;

  localparam logic [7:0] MAX_SENTENCE = 8'd128;
  localparam logic [5:0] MAX_FIELDS   = 6'd32;
  localparam logic [5:0] COUNT_MAX    = 6'd63;
  localparam logic [2:0] TAG_LEN      = 3'd6;

  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_COMMA  = 8'h2c;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_MALFORMED   = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_FEW_FIELDS  = 3'd4,
    ST_UNKNOWN_TAG = 3'd5,
    ST_TOO_LONG    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    MT_NONE = 3'd0,
    MT_GGA  = 3'd1,
    MT_GLL  = 3'd2,
    MT_GSA  = 3'd3,
    MT_GSV  = 3'd4,
    MT_RMC  = 3'd5,
    MT_VTG  = 3'd6,
    MT_ZDA  = 3'd7
  } msg_type_t;

  typedef enum logic [1:0] {
    TK_GP    = 2'd0,
    TK_GL    = 2'd1,
    TK_BD    = 2'd2,
    TK_OTHER = 2'd3
  } talker_t;

  // sentence state as seen by the verdict logic on the closing word
  typedef struct packed {
    logic             finish;
    logic             too_long;
    logic [5:0]       star_count;
    logic [5:0]       comma_count;
    logic [7:0]       running_xor;
    logic [5:0][7:0]  tag_chars;
    logic [2:0]       tag_length;
    logic [1:0][7:0]  hex_digits;
    logic [1:0]       hex_length;
  } sent_state_t;

  typedef struct packed {
    logic [7:0] computed_checksum;
    logic [5:0] field_count;
    talker_t    talker;
    msg_type_t  msg_type;
    status_t    status;
  } verdict_t;

  function automatic logic [3:0] min_fields(msg_type_t mt);
    logic [3:0] need;
    case (mt)
      MT_GGA:  need = 4'd13;
      MT_GLL:  need = 4'd8;
      MT_GSA:  need = 4'd7;
      MT_GSV:  need = 4'd8;
      MT_RMC:  need = 4'd11;
      MT_VTG:  need = 4'd5;
      MT_ZDA:  need = 4'd7;
      default: need = 4'd0;
    endcase
    return need;
  endfunction

endpackage

// ===== rtl/core/nsc_track.sv =====
// nsc_track: per-word sentence state (counts, xor, tag and checksum token)
// depends on nsc_pkg
module nsc_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output nsc_pkg::sent_state_t snap
);
  import nsc_pkg::*;

  logic [7:0]      byte_count_r, byte_count_nxt;
  logic            prev_cr_r, prev_cr_nxt;
  logic            ended_r, ended_nxt;
  logic [7:0]      xor_r, xor_nxt;
  logic [5:0]      star_r, star_nxt;
  logic [5:0]      comma_r, comma_nxt;
  logic [5:0][7:0] tag_r, tag_nxt;
  logic [2:0]      tag_len_r, tag_len_nxt;
  logic [1:0][7:0] hex_r, hex_nxt;
  logic [1:0]      hex_len_r, hex_len_nxt;
  logic            too_long_r, too_long_nxt;
  logic            finish;

  assign finish = prev_cr_r && (rx_byte == CHAR_LF) && (byte_count_r >= 8'd2);

  always_comb begin
    byte_count_nxt = byte_count_r;
    too_long_nxt   = too_long_r;
    ended_nxt      = ended_r;
    xor_nxt        = xor_r;
    star_nxt       = star_r;
    comma_nxt      = comma_r;
    tag_nxt        = tag_r;
    tag_len_nxt    = tag_len_r;
    hex_nxt        = hex_r;
    hex_len_nxt    = hex_len_r;
    prev_cr_nxt    = (rx_byte == CHAR_CR);

    if (byte_count_r >= MAX_SENTENCE) begin
      too_long_nxt = 1'b1;
    end else begin
      byte_count_nxt = byte_count_r + 8'd1;
    end

    if (!ended_r) begin
      if (rx_byte == CHAR_CR || rx_byte == CHAR_NUL) begin
        ended_nxt = 1'b1;
      end else if (rx_byte == CHAR_STAR) begin
        if (star_r != COUNT_MAX) star_nxt = star_r + 6'd1;
      end else if (star_r == 6'd0) begin
        // the start character stays out of the checksum
        if (byte_count_r != 8'd0) xor_nxt = xor_r ^ rx_byte;
        if (rx_byte == CHAR_COMMA) begin
          if (comma_r != COUNT_MAX) comma_nxt = comma_r + 6'd1;
        end else if (comma_r == 6'd0) begin
          // only the first six tag characters can ever match
          if (tag_len_r < TAG_LEN) tag_nxt[tag_len_r] = rx_byte;
          if (tag_len_r != 3'd7) tag_len_nxt = tag_len_r + 3'd1;
        end
      end else if (star_r == 6'd1) begin
        if (hex_len_r < 2'd2) hex_nxt[hex_len_r[0]] = rx_byte;
        if (hex_len_r != 2'd3) hex_len_nxt = hex_len_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      prev_cr_r    <= 1'b0;
      ended_r      <= 1'b0;
      xor_r        <= '0;
      star_r       <= '0;
      comma_r      <= '0;
      tag_len_r    <= '0;
      hex_len_r    <= '0;
      too_long_r   <= 1'b0;
    end else if (step) begin
      if (finish) begin
        byte_count_r <= '0;
        prev_cr_r    <= 1'b0;
        ended_r      <= 1'b0;
        xor_r        <= '0;
        star_r       <= '0;
        comma_r      <= '0;
        tag_len_r    <= '0;
        hex_len_r    <= '0;
        too_long_r   <= 1'b0;
      end else begin
        byte_count_r <= byte_count_nxt;
        prev_cr_r    <= prev_cr_nxt;
        ended_r      <= ended_nxt;
        xor_r        <= xor_nxt;
        star_r       <= star_nxt;
        comma_r      <= comma_nxt;
        tag_len_r    <= tag_len_nxt;
        hex_len_r    <= hex_len_nxt;
        too_long_r   <= too_long_nxt;
      end
    end
  end

  // characters are only read once their length count covers them
  always_ff @(posedge clk) begin
    if (step) begin
      tag_r <= tag_nxt;
      hex_r <= hex_nxt;
    end
  end

  // content is already closed by the cr, so only the length flag moves
  always_comb begin
    snap.finish      = finish;
    snap.too_long    = too_long_nxt;
    snap.star_count  = star_r;
    snap.comma_count = comma_r;
    snap.running_xor = xor_r;
    snap.tag_chars   = tag_r;
    snap.tag_length  = tag_len_r;
    snap.hex_digits  = hex_r;
    snap.hex_length  = hex_len_r;
  end

endmodule

// ===== rtl/core/nsc_verdict.sv =====
// nsc_verdict: checksum compare, tag lookup and status priority
// depends on nsc_pkg
module nsc_verdict (
  input  nsc_pkg::sent_state_t snap,
  output nsc_pkg::verdict_t    verdict
);
  import nsc_pkg::*;

  function automatic logic [4:0] hex_val(logic [7:0] h);
    // bit 4 set means a valid digit
    logic [4:0] v;
    if (h >= "A" && h <= "F") v = {1'b1, h[3:0] + 4'd9};
    else if (h >= "a" && h <= "f") v = {1'b1, h[3:0] + 4'd9};
    else if (h >= "0" && h <= "9") v = {1'b1, h[3:0]};
    else v = 5'd0;
    return v;
  endfunction

  logic [4:0]  hi, lo;
  logic        cks_ok;
  logic [6:0]  fields_wide;
  logic [5:0]  fields;
  talker_t     tk;
  logic        tk_ok;
  msg_type_t   mt;
  logic [23:0] kind;

  assign hi = hex_val(snap.hex_digits[0]);
  assign lo = hex_val(snap.hex_digits[1]);
  assign cks_ok = (snap.hex_length == 2'd2) && hi[4] && lo[4] &&
                  ({hi[3:0], lo[3:0]} == snap.running_xor);

  assign fields_wide = {1'b0, snap.comma_count} + 7'd1;
  assign fields = fields_wide[6] ? COUNT_MAX : fields_wide[5:0];

  assign kind = {snap.tag_chars[3], snap.tag_chars[4], snap.tag_chars[5]};

  always_comb begin
    tk    = TK_OTHER;
    tk_ok = 1'b0;
    mt    = MT_NONE;
    if (snap.tag_length == TAG_LEN && snap.tag_chars[0] == CHAR_DOLLAR) begin
      tk_ok = 1'b1;
      if (snap.tag_chars[1] == "G" && snap.tag_chars[2] == "P") tk = TK_GP;
      else if (snap.tag_chars[1] == "G" && snap.tag_chars[2] == "L") tk = TK_GL;
      else if (snap.tag_chars[1] == "B" && snap.tag_chars[2] == "D") tk = TK_BD;
      else tk_ok = 1'b0;
    end
    if (tk_ok) begin
      if (kind == "GSA") mt = MT_GSA;
      else if (kind == "GSV") mt = MT_GSV;
      else if (tk == TK_GP) begin
        if (kind == "GGA") mt = MT_GGA;
        else if (kind == "GLL") mt = MT_GLL;
        else if (kind == "RMC") mt = MT_RMC;
        else if (kind == "VTG") mt = MT_VTG;
        else if (kind == "ZDA") mt = MT_ZDA;
      end
    end
  end

  always_comb begin
    verdict.computed_checksum = snap.running_xor;
    verdict.field_count       = fields;
    verdict.msg_type          = MT_NONE;
    verdict.talker            = TK_OTHER;
    if (snap.too_long) begin
      verdict.status = ST_TOO_LONG;
    end else if (snap.star_count >= MAX_FIELDS) begin
      verdict.status = ST_OVERFLOW;
    end else if (snap.star_count != 6'd1) begin
      verdict.status = ST_MALFORMED;
    end else if (!cks_ok) begin
      verdict.status = ST_MISMATCH;
    end else if (snap.comma_count >= MAX_FIELDS) begin
      verdict.status = ST_OVERFLOW;
    end else if (mt == MT_NONE) begin
      verdict.status = ST_UNKNOWN_TAG;
    end else begin
      verdict.msg_type = mt;
      verdict.talker   = tk;
      verdict.status   = (fields < {2'b00, min_fields(mt)}) ? ST_FEW_FIELDS : ST_OK;
    end
  end

endmodule

// ===== rtl/core/nmea_sentence_checker.sv =====
// nmea_sentence_checker: top level, input word register, result register
// depends on nsc_pkg, nsc_track and nsc_verdict
//
// usage
//   in_*  : one received byte per word, in_tdata[7:0]
//   out_* : one verdict per sentence that closes with cr lf after at least
//           one earlier byte; no word for any other byte
// timing
//   an accepted byte sits in the input register, where the state update
//   and the verdict are worked out from it; the verdict for a closing lf
//   goes into the output register that drives out_tvalid. one byte per
//   cycle is taken back to back unless a closing lf waits for the slot.
// reset
//   rst_n low clears the sentence state and both valid flags; the first
//   byte after reset starts a new sentence
// stall
//   a waiting verdict holds in the output register; bytes that close no
//   sentence keep flowing, and only a second closing lf waits in the
//   input register, dropping in_tready, until out_tready frees the slot
module nmea_sentence_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [5:3] msg_type, [7:6] talker,
                                  // [13:8] field_count, [21:14] computed_checksum
);
  import nsc_pkg::*;

  logic        in_valid_r;
  logic [7:0]  byte_r;
  logic        out_valid_r;
  verdict_t    out_r;
  sent_state_t snap;
  verdict_t    verdict;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!snap.finish || out_free);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) byte_r <= in_tdata;
  end

  nsc_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (byte_r),
    .snap    (snap)
  );

  nsc_verdict u_verdict (
    .snap    (snap),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && snap.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap.finish) out_r <= verdict;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

  // a held input word must not change while it waits
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(byte_r))
    else $error("input word lost while stalled");

  // a closing word is never moved into a full, stalled result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(advance && snap.finish))
    else $error("verdict overwritten");

  // a clean verdict always names a sentence type
  a_ok_has_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_OK |-> out_r.msg_type != MT_NONE)
    else $error("ok verdict without type");

  // without a type there is no talker
  a_none_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.msg_type == MT_NONE |-> out_r.talker == TK_OTHER)
    else $error("talker given without type");

  // field count starts at one
  a_fields_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.field_count != 6'd0)
    else $error("zero field count");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for nmea_sentence_checker, byte stream in, verdicts out
// holds its own sentence tracker that predicts each verdict; depends on nsc_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import nsc_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int ITEM_TARGET = 1750;
  localparam int CALM_FROM   = 1400;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 64;
  localparam int VALID_TAGS  = 11;
  localparam int TAG_COUNT   = 18;

  typedef enum {
    CK_GOOD, CK_LOWER, CK_WRONG, CK_SHORT, CK_LONG, CK_NOT_HEX, CK_NO_STAR, CK_TWO_STARS
  } ck_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [2:0] status, [5:3] msg_type, [7:6] talker,
                            // [13:8] field_count, [21:14] computed_checksum

  nmea_sentence_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // tracks the sentence in progress and queues the verdict due for each closing lf
  class sentence_tracker;
    logic [7:0] byte_cnt;
    bit         last_cr;
    bit         content_done;
    bit         overlong;
    logic [7:0] xor_acc;
    logic [5:0] stars;
    logic [5:0] commas;
    logic [7:0] tag [7];
    logic [2:0] tag_len;
    logic [7:0] hex [2];
    logic [1:0] hex_len;
    verdict_t   due_verdicts[$];
    int         errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      byte_cnt = 8'd0;
      last_cr = 1'b0;
      content_done = 1'b0;
      overlong = 1'b0;
      xor_acc = 8'd0;
      stars = 6'd0;
      commas = 6'd0;
      foreach (tag[i]) tag[i] = 8'd0;
      tag_len = 3'd0;
      foreach (hex[i]) hex[i] = 8'd0;
      hex_len = 2'd0;
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "0" && c <= "9") return c - "0";
      return -1;
    endfunction

    function bit is_type(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      return tag[3] == a && tag[4] == b && tag[5] == c;
    endfunction

    function int fields_needed(msg_type_t mt);
      case (mt)
        MT_GGA:  return 13;
        MT_GLL:  return 8;
        MT_GSA:  return 7;
        MT_GSV:  return 8;
        MT_RMC:  return 11;
        MT_VTG:  return 5;
        MT_ZDA:  return 7;
        default: return 0;
      endcase
    endfunction

    function void classify(output msg_type_t mt, output talker_t tk);
      talker_t who;
      mt = MT_NONE;
      tk = TK_OTHER;
      if (tag_len != TAG_LEN || tag[0] != CHAR_DOLLAR) return;
      if (tag[1] == "G" && tag[2] == "P") who = TK_GP;
      else if (tag[1] == "G" && tag[2] == "L") who = TK_GL;
      else if (tag[1] == "B" && tag[2] == "D") who = TK_BD;
      else return;
      if (is_type("G", "S", "A")) mt = MT_GSA;
      else if (is_type("G", "S", "V")) mt = MT_GSV;
      else if (who == TK_GP) begin
        // the remaining types only come from the gps talker
        if (is_type("G", "G", "A")) mt = MT_GGA;
        else if (is_type("G", "L", "L")) mt = MT_GLL;
        else if (is_type("R", "M", "C")) mt = MT_RMC;
        else if (is_type("V", "T", "G")) mt = MT_VTG;
        else if (is_type("Z", "D", "A")) mt = MT_ZDA;
      end
      if (mt != MT_NONE) tk = who;
    endfunction

    function verdict_t judge();
      verdict_t  v;
      int        fields;
      int        hi;
      int        lo;
      msg_type_t mt;
      talker_t   tk;
      fields = int'(commas) + 1;
      if (fields > 63) fields = 63;
      mt = MT_NONE;
      tk = TK_OTHER;
      if (overlong) v.status = ST_TOO_LONG;
      else if (stars >= MAX_FIELDS) v.status = ST_OVERFLOW;
      else if (stars != 6'd1) v.status = ST_MALFORMED;
      else begin
        hi = nibble(hex[0]);
        lo = nibble(hex[1]);
        if (hex_len != 2'd2 || hi < 0 || lo < 0 || hi * 16 + lo != int'(xor_acc))
          v.status = ST_MISMATCH;
        else if (commas >= MAX_FIELDS) v.status = ST_OVERFLOW;
        else begin
          classify(mt, tk);
          if (mt == MT_NONE) v.status = ST_UNKNOWN_TAG;
          else if (fields < fields_needed(mt)) v.status = ST_FEW_FIELDS;
          else v.status = ST_OK;
        end
      end
      v.msg_type = mt;
      v.talker = tk;
      v.field_count = 6'(fields);
      v.computed_checksum = xor_acc;
      return v;
    endfunction

    function void take_byte(logic [7:0] b);
      bit         closing;
      logic [7:0] pos;
      closing = last_cr && b == CHAR_LF && byte_cnt >= 8'd2;
      pos = byte_cnt;
      if (byte_cnt >= MAX_SENTENCE) overlong = 1'b1;
      else byte_cnt++;
      if (!content_done) begin
        if (b == CHAR_CR || b == CHAR_NUL) begin
          content_done = 1'b1;
        end else if (b == CHAR_STAR) begin
          if (stars < COUNT_MAX) stars++;
        end else if (stars == 6'd0) begin
          // the start character stays out of the checksum
          if (pos >= 8'd1) xor_acc ^= b;
          if (b == CHAR_COMMA) begin
            if (commas < COUNT_MAX) commas++;
          end else if (commas == 6'd0 && tag_len < 3'd7) begin
            tag[tag_len] = b;
            tag_len++;
          end
        end else if (stars == 6'd1) begin
          if (hex_len < 2'd2) hex[hex_len[0]] = b;
          if (hex_len < 2'd3) hex_len++;
        end
      end
      last_cr = (b == CHAR_CR);
      if (closing) begin
        due_verdicts.push_back(judge());
        clear();
      end
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void match_verdict(logic [23:0] word);
      verdict_t got;
      verdict_t want;
      got = verdict_t'(word[21:0]);
      if (due_verdicts.size() == 0) begin
        fail($sformatf("%0t: verdict word %06h with no sentence closed", $realtime, word));
        return;
      end
      want = due_verdicts.pop_front();
      if (got.status !== want.status || got.msg_type !== want.msg_type ||
          got.talker !== want.talker || got.field_count !== want.field_count ||
          got.computed_checksum !== want.computed_checksum)
        fail($sformatf({"%0t: verdict mismatch, expected status %0d type %0d talker %0d",
                        " fields %0d xor %02h, got status %0d type %0d talker %0d",
                        " fields %0d xor %02h"}, $realtime,
                       want.status, want.msg_type, want.talker, want.field_count,
                       want.computed_checksum, got.status, got.msg_type, got.talker,
                       got.field_count, got.computed_checksum));
    endfunction

    function void close();
      if (due_verdicts.size() != 0)
        fail($sformatf("%0d verdicts never arrived", due_verdicts.size()));
      errors += (due_verdicts.size() > 1) ? due_verdicts.size() - 1 : 0;
    endfunction
  endclass

  sentence_tracker tracker;
  logic [7:0]      frame[$];
  int              bytes_sent = 0;
  int              quiet_cycles = 0;
  bit              in_idle_on;
  bit              out_idle_on;
  bit              hold_request;

  string tag_pool [TAG_COUNT] = '{
    "$GPGGA", "$GPGLL", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG", "$GPZDA", "$GLGSA",
    "$GLGSV", "$BDGSA", "$BDGSV", "$GLGGA", "$BDRMC", "$GNGSA", "$GPXYZ", "$GPGG",
    "$GPGGAX", "$gpgga"
  };

  // both channels seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.match_verdict(out_tdata);
      if (in_tvalid && in_tready) begin
        tracker.take_byte(in_tdata);
        bytes_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return "0" + n;
    return 8'((lower ? "a" : "A") + n - 10);
  endfunction

  function automatic logic [7:0] field_char();
    string pool = "0123456789.-ABCDEFNSEWMKTabcdef";
    if ($urandom_range(0, 19) == 0) return 8'h80 | 8'($urandom_range(0, 127));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endfunction

  function automatic void put_fields(int n, int max_len);
    for (int i = 0; i < n; i++) begin
      frame.push_back(CHAR_COMMA);
      repeat ($urandom_range(0, max_len)) frame.push_back(field_char());
    end
  endfunction

  // closes the frame with a checksum token of the given kind and cr lf
  function automatic void seal(ck_mode_t mode);
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 1; i < frame.size(); i++) sum ^= frame[i];
    if (mode == CK_WRONG) sum ^= 8'(1 << $urandom_range(0, 7));
    if (mode != CK_NO_STAR) frame.push_back(CHAR_STAR);
    case (mode)
      CK_NO_STAR: ;
      CK_SHORT: frame.push_back(hex_char(sum[7:4], 1'b0));
      CK_NOT_HEX: begin
        frame.push_back($urandom_range(0, 1) ? "G" : "g");
        frame.push_back(hex_char(sum[3:0], 1'b0));
      end
      default: begin
        frame.push_back(hex_char(sum[7:4], mode == CK_LOWER));
        frame.push_back(hex_char(sum[3:0], mode == CK_LOWER));
        if (mode == CK_LONG) frame.push_back(hex_char(sum[3:0], 1'b0));
        if (mode == CK_TWO_STARS) frame.push_back(CHAR_STAR);
      end
    endcase
    frame.push_back(CHAR_CR);
    frame.push_back(CHAR_LF);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
    frame.delete();
  endtask

  task automatic sentence(string tag_text, int nfields, ck_mode_t mode);
    put_text(tag_text);
    put_fields(nfields, 4);
    seal(mode);
    send_frame();
  endtask

  // "X" cr lf always closes whatever is in progress
  task automatic flush_sentence();
    put_text("X\r\n");
    send_frame();
  endtask

  task automatic padded_sentence(int total);
    put_text("$GPVTG");
    put_fields(4, 2);
    while (frame.size() < total - 5) frame.push_back("0");
    seal(CK_GOOD);
    send_frame();
  endtask

  task automatic star_flood(int extra);
    put_text("$GPVTG");
    put_fields(4, 2);
    repeat (extra) frame.push_back(CHAR_STAR);
    seal(CK_GOOD);
    send_frame();
  endtask

  task automatic comma_flood(int n);
    put_text("$GPGGA");
    put_fields(n, 0);
    seal(CK_GOOD);
    send_frame();
  endtask

  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (tracker.due_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // every type at its minimum field count, then one gga below it
    sentence("$GPGGA", 12, CK_GOOD);
    sentence("$GPGLL", 7, CK_LOWER);
    sentence("$GPGSA", 6, CK_GOOD);
    sentence("$GLGSV", 7, CK_GOOD);
    sentence("$BDGSA", 6, CK_GOOD);
    sentence("$GLGSA", 6, CK_GOOD);
    sentence("$BDGSV", 7, CK_GOOD);
    sentence("$GPGSV", 7, CK_GOOD);
    sentence("$GPRMC", 10, CK_LOWER);
    sentence("$GPVTG", 4, CK_GOOD);
    sentence("$GPZDA", 6, CK_GOOD);
    sentence("$GPGGA", 10, CK_GOOD);
    // tags that must not match
    sentence("$GLGGA", 12, CK_GOOD);
    sentence("$GPGGAX", 12, CK_GOOD);
    sentence("GPGGA", 12, CK_GOOD);
    sentence("$GPXYZ", 3, CK_GOOD);
    // checksum tokens
    sentence("$GPRMC", 10, CK_WRONG);
    sentence("$GPRMC", 10, CK_SHORT);
    sentence("$GPRMC", 10, CK_LONG);
    sentence("$GPRMC", 10, CK_NOT_HEX);
    sentence("$GPRMC", 10, CK_NO_STAR);
    sentence("$GPRMC", 10, CK_TWO_STARS);
    star_flood(31);
    comma_flood(40);
    comma_flood(70);
    padded_sentence(128);
    padded_sentence(129);
    padded_sentence(150);
    // star as the very first byte: empty message part
    seal(CK_GOOD);
    send_frame();
    // nul ends the content early
    put_text("$GPVTG,");
    frame.push_back(CHAR_NUL);
    put_text(",,");
    seal(CK_GOOD);
    send_frame();
    put_text("$GPVTG,");
    frame.push_back(8'hff);
    frame.push_back(8'h80);
    frame.push_back(8'h7f);
    put_text(",,,");
    seal(CK_GOOD);
    send_frame();
    // cr lf with too few earlier bytes does not close the sentence
    put_text("\r\n");
    send_frame();
    sentence("$GPVTG", 4, CK_GOOD);
    put_text("A\r\n");
    send_frame();
  endtask

  // receiver holds off while short sentences keep coming, so the input stalls
  task automatic squeeze_phase();
    in_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (10) begin
      put_text("AB");
      seal(CK_NO_STAR);
      send_frame();
      sentence("$GPVTG", 4, CK_GOOD);
    end
    in_idle_on = 1'b1;
  endtask

  task automatic random_case();
    int       kind;
    int       p;
    string    t;
    ck_mode_t mode;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      t = ($urandom_range(0, 9) < 8) ? tag_pool[$urandom_range(0, VALID_TAGS - 1)]
                                     : tag_pool[$urandom_range(0, TAG_COUNT - 1)];
      if ($urandom_range(0, 9) < 8) mode = $urandom_range(0, 1) ? CK_LOWER : CK_GOOD;
      else mode = ck_mode_t'($urandom_range(CK_WRONG, CK_TWO_STARS));
      put_text(t);
      put_fields($urandom_range(0, 15), 6);
      seal(mode);
      if (kind >= 70) begin
        // damage one byte of the sentence
        p = $urandom_range(1, frame.size() - 3);
        case ($urandom_range(0, 4))
          0: frame.insert(p, CHAR_STAR);
          1: frame.insert(p, CHAR_NUL);
          2: frame.insert(p, CHAR_CR);
          3: frame[p] = 8'($urandom_range(0, 255));
          default: frame.delete(p);
        endcase
        put_text("X\r\n");
      end
      send_frame();
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
      send_frame();
      flush_sentence();
    end else begin
      case ($urandom_range(0, 4))
        0: padded_sentence($urandom_range(0, 3) == 0 ? 128 : $urandom_range(129, 150));
        1: star_flood($urandom_range(29, 34));
        2: comma_flood($urandom_range(28, 70));
        3: begin
          seal(CK_GOOD);
          send_frame();
        end
        default: begin
          put_text("\r\n");
          send_frame();
          flush_sentence();
        end
      endcase
    end
  endtask

  task automatic run_random();
    int  next_pause;
    bit  calm;
    next_pause = bytes_sent + 400;
    calm = 1'b0;
    while (bytes_sent < ITEM_TARGET) begin
      if (!calm && bytes_sent >= CALM_FROM) begin
        drain_results();
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        calm = 1'b1;
      end else if (!calm) begin
        in_idle_on = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      random_case();
      if (bytes_sent >= next_pause) begin
        drain_results();
        next_pause = bytes_sent + 400;
      end
    end
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    run_directed();
    drain_results();
    squeeze_phase();
    drain_results();
    run_random();
    drain_results();
    repeat (4) @(posedge clk);
    tracker.close();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nsc_pkg.sv
rtl/core/nsc_track.sv
rtl/core/nsc_verdict.sv
rtl/core/nmea_sentence_checker.sv
sim/tb_top.sv
